// ===== hw/rtl/spl_pkg.sv =====
// Shared types and constants for the shared-pool linked stacks block.
package spl_pkg;

  // Fixed field widths.
  localparam int DATA_W = 32;
  localparam int SEL_W  = 2;

  // The free map is kept as rows of this many bits.
  localparam int WORD_W = 32;
  localparam int WBIT_W = 5;

  // Action codes.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch the transaction and start the memory reads
    logic clr_step;  // write one all-free row of the free map
    logic scan;      // read the free-map row at the search pointer
    logic push;      // commit a push
    logic pop;       // commit a pop
    logic fail;      // report a failed operation
    logic hint_inc;  // row at the search pointer is full, move on
  } spl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // clearing pass is at its last row
    logic sel_ok;    // stack selector addresses an existing stack
    logic is_pop;    // latched action is a pop
    logic head_ok;   // selected stack is not empty
    logic hint_ok;   // search pointer is inside the free map
    logic row_free;  // free-map row at the search pointer has a free entry
  } spl_status_t;

endpackage

// ===== hw/rtl/spl_ctrl.sv =====
// Controller state machine for the shared-pool linked stacks.
module spl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  spl_pkg::spl_status_t st_i,
  output spl_pkg::spl_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) begin
          state_d = ST_IDLE;
          busy_d  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
          busy_d       = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
        if (!st_i.sel_ok) begin
          cmd_o.fail = 1'b1;
        end else if (st_i.is_pop) begin
          if (st_i.head_ok) cmd_o.pop = 1'b1;
          else cmd_o.fail = 1'b1;
        end else if (!st_i.hint_ok) begin
          cmd_o.fail = 1'b1;
        end else if (st_i.row_free) begin
          cmd_o.push = 1'b1;
        end else begin
          // Keep searching for a free entry in the next row.
          cmd_o.hint_inc = 1'b1;
          state_d        = ST_SCAN;
          busy_d         = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  // State and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

endmodule

// ===== hw/rtl/spl_dp.sv =====
// Datapath for the shared-pool linked stacks: entry pool, free map and heads.
module spl_dp #(
  parameter int DEPTH  = 256,
  parameter int STACKS = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spl_pkg::spl_cmd_t                 cmd_i,
  output spl_pkg::spl_status_t              st_o,
  input  logic                              action_i,
  input  logic [spl_pkg::SEL_W-1:0]         stack_sel_i,
  input  logic signed [spl_pkg::DATA_W-1:0] push_data_i,
  output logic                              valid_o,
  output logic                              done_ok_o,
  output logic signed [spl_pkg::DATA_W-1:0] pop_data_o
);

  localparam int DW   = spl_pkg::DATA_W;
  localparam int WW   = spl_pkg::WORD_W;
  localparam int BW   = spl_pkg::WBIT_W;
  localparam int AW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int ROWS = (DEPTH + WW - 1) / WW;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int HW   = $clog2(ROWS + 1);
  localparam int SLW  = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam int EW   = DW + AW;

  // Latched transaction.
  logic                         act_q;
  logic [spl_pkg::SEL_W-1:0]    sel_q;
  logic [DW-1:0]                data_q;

  // Stack heads and free-map search pointer.
  logic [AW-1:0] head_q [STACKS];
  logic [HW-1:0] hint_q, hint_d;

  // Memories.
  logic [EW-1:0] entry_mem [DEPTH];
  logic [EW-1:0] entry_rd_q;
  logic [WW-1:0] free_mem [ROWS];
  logic [WW-1:0] free_rd_q;

  // Result registers.
  logic          valid_q;
  logic          ok_q;
  logic [DW-1:0] pop_data_q;

  logic [AW-1:0] head_in, head_cur;
  logic [RW-1:0] hint_row, head_row, head_in_row;
  logic [BW-1:0] head_bit;
  logic [WW-1:0] row_mask, cand;
  logic [BW-1:0] enc;
  logic [AW-1:0] push_idx;
  logic [DW-1:0] ent_data;
  logic [AW-1:0] ent_link;

  logic          ent_we, ent_re;
  logic [IW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_wdata;
  logic          free_we, free_re;
  logic [RW-1:0] free_waddr, free_raddr;
  logic [WW-1:0] free_wdata;

  // Head lookups for the incoming and the latched selector.
  always_comb begin
    head_in  = AW'(DEPTH);
    head_cur = AW'(DEPTH);
    if (int'(stack_sel_i) < STACKS) head_in = head_q[SLW'(stack_sel_i)];
    if (int'(sel_q) < STACKS) head_cur = head_q[SLW'(sel_q)];
  end

  assign hint_row    = RW'(hint_q);
  assign head_row    = RW'(head_cur >> BW);
  assign head_bit    = BW'(head_cur);
  assign head_in_row = RW'(head_in >> BW);
  assign ent_data    = entry_rd_q[EW-1:AW];
  assign ent_link    = entry_rd_q[AW-1:0];

  // Bits of the searched row that stand for real entries.
  always_comb begin
    for (int b = 0; b < WW; b++) begin
      row_mask[b] = ((int'(hint_row) * WW) + b) < DEPTH;
    end
  end

  assign cand = free_rd_q & row_mask;

  // Lowest free bit of the searched row.
  always_comb begin
    enc = '0;
    for (int b = WW - 1; b >= 0; b--) begin
      if (cand[b]) enc = BW'(b);
    end
  end

  assign push_idx = AW'((int'(hint_row) * WW) + int'(enc));

  // Status toward the controller.
  always_comb begin
    st_o.clr_last = (hint_q == HW'(ROWS - 1));
    st_o.sel_ok   = int'(sel_q) < STACKS;
    st_o.is_pop   = (act_q == spl_pkg::ACT_POP);
    st_o.head_ok  = head_cur < AW'(DEPTH);
    st_o.hint_ok  = hint_q < HW'(ROWS);
    st_o.row_free = |cand;
  end

  // Memory port control.
  always_comb begin
    ent_we     = cmd_i.push;
    ent_waddr  = IW'(push_idx);
    ent_wdata  = {data_q, head_cur};
    ent_re     = cmd_i.accept;
    ent_raddr  = IW'(head_in);

    free_re    = cmd_i.accept | cmd_i.scan;
    free_raddr = (cmd_i.accept && action_i == spl_pkg::ACT_POP) ? head_in_row : hint_row;
    free_we    = cmd_i.clr_step | cmd_i.push | cmd_i.pop;
    free_waddr = hint_row;
    free_wdata = '1;
    if (cmd_i.push) begin
      free_wdata = free_rd_q & ~(WW'(1) << enc);
    end else if (cmd_i.pop) begin
      free_waddr = head_row;
      free_wdata = free_rd_q | (WW'(1) << head_bit);
    end
  end

  // Entry pool memory.
  always_ff @(posedge clk_i) begin
    if (ent_we) entry_mem[ent_waddr] <= ent_wdata;
    if (ent_re) entry_rd_q <= entry_mem[ent_raddr];
  end

  // Free map memory.
  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[free_waddr] <= free_wdata;
    if (free_re) free_rd_q <= free_mem[free_raddr];
  end

  // Latch the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q  <= action_i;
      sel_q  <= stack_sel_i;
      data_q <= push_data_i;
    end
  end

  // Search pointer: clearing counter after reset, then lowest row that may hold a free entry.
  always_comb begin
    hint_d = hint_q;
    if (cmd_i.clr_step) begin
      hint_d = st_o.clr_last ? '0 : hint_q + HW'(1);
    end else if (cmd_i.hint_inc) begin
      hint_d = hint_q + HW'(1);
    end else if (cmd_i.pop && (HW'(head_row) < hint_q)) begin
      hint_d = HW'(head_row);
    end
  end

  // Heads and search pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hint_q <= '0;
      for (int s = 0; s < STACKS; s++) head_q[s] <= AW'(DEPTH);
    end else begin
      hint_q <= hint_d;
      if (cmd_i.push) head_q[SLW'(sel_q)] <= push_idx;
      else if (cmd_i.pop) head_q[SLW'(sel_q)] <= ent_link;
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.push | cmd_i.pop | cmd_i.fail;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push | cmd_i.pop | cmd_i.fail) begin
      ok_q       <= cmd_i.push | cmd_i.pop;
      pop_data_q <= cmd_i.pop ? ent_data : '0;
    end
  end

  assign valid_o    = valid_q;
  assign done_ok_o  = ok_q;
  assign pop_data_o = pop_data_q;

`ifndef SYNTH
  // A result never lasts more than one cycle; the next one needs a new transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_q |=> !valid_q)
    else $error("back-to-back result strobes");

  // A failed operation reports zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ok_q) |-> (pop_data_q == '0))
    else $error("failed result carries data");

  // The search pointer never runs past the end of the free map.
  assert property (@(posedge clk_i) disable iff (!rst_ni) hint_q <= HW'(ROWS))
    else $error("free-map search pointer out of range");

  // A push only commits with a real free entry in the searched row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (st_o.hint_ok && st_o.row_free && st_o.sel_ok))
    else $error("push committed without a free entry");
`endif

endmodule

// ===== hw/rtl/shared_pool_linked_stacks.sv =====
// Shared-pool linked stacks: several LIFO stacks drawing entries from one pool.
//
// Usage: drive action_i, stack_sel_i and push_data_i and raise start; the
// transaction is taken at a clock edge where start is high and busy is low.
// Each transaction gives exactly one result: valid_o is high for one cycle
// with done_ok_o and pop_data_o. The receiver cannot stall the result.
// A push takes the lowest free entry; a pop returns the top entry of the
// stack and frees it. Full pool, empty stack and a bad selector fail.
// valid_o is registered from the commit in the execute state, which
// follows acceptance unless a push first scans the free map. Busy drops
// in the cycle the result shows, so a new transaction is taken only
// after the last one has reported. A push whose free entry is not in the
// row of 32 entries held by the search pointer goes through the scan and
// execute states for each full row it steps over (one free-map read port).
// Reset: all stacks become empty and the free map is cleared by a pass over
// its ceil(DEPTH/32) rows (8 at DEPTH 256), during which busy stays high.
module shared_pool_linked_stacks #(
  parameter int DEPTH  = 256,
  parameter int STACKS = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action_i,
  input  logic [spl_pkg::SEL_W-1:0]         stack_sel_i,
  input  logic signed [spl_pkg::DATA_W-1:0] push_data_i,
  output logic                              valid_o,
  output logic                              done_ok_o,
  output logic signed [spl_pkg::DATA_W-1:0] pop_data_o
);

  spl_pkg::spl_cmd_t    cmd;
  spl_pkg::spl_status_t status;

  // Sequencing of each transaction.
  spl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .st_i   (status),
    .cmd_o  (cmd)
  );

  // Pool, free map and head pointers.
  spl_dp #(
    .DEPTH  (DEPTH),
    .STACKS (STACKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (status),
    .action_i    (action_i),
    .stack_sel_i (stack_sel_i),
    .push_data_i (push_data_i),
    .valid_o     (valid_o),
    .done_ok_o   (done_ok_o),
    .pop_data_o  (pop_data_o)
  );

endmodule

// ===== tb/sv/shared_pool_linked_stacks_tb.sv =====
// Self-checking testbench for the shared-pool linked stacks block.
module shared_pool_linked_stacks_tb;

  localparam int DATA_W      = spl_pkg::DATA_W;
  localparam int SEL_W       = spl_pkg::SEL_W;
  localparam int DEPTH       = 256;
  localparam int STACKS      = 3;
  localparam int NO_ENTRY    = DEPTH;
  localparam int BAD_SEL     = STACKS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;

  // One expected result of a transaction.
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data;
  } stack_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic                     action_i;
  logic [SEL_W-1:0]         stack_sel_i;
  logic signed [DATA_W-1:0] push_data_i;
  logic                     valid_o;
  logic                     done_ok_o;
  logic signed [DATA_W-1:0] pop_data_o;

  // Shadow copy of the pool and the stack heads.
  logic signed [DATA_W-1:0] pool_data [DEPTH];
  int                       pool_link [DEPTH];
  bit                       pool_free [DEPTH];
  int                       stack_top [STACKS];
  int                       pool_used;

  stack_result_t expected_results[$];
  int            error_count;
  int            cycle_count;
  int            idle_pct;

  shared_pool_linked_stacks #(
    .DEPTH (DEPTH),
    .STACKS(STACKS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .action_i   (action_i),
    .stack_sel_i(stack_sel_i),
    .push_data_i(push_data_i),
    .valid_o    (valid_o),
    .done_ok_o  (done_ok_o),
    .pop_data_o (pop_data_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow pool and return what the block must report.
  function automatic stack_result_t predict_stack_op(logic act, logic [SEL_W-1:0] sel,
                                                     logic signed [DATA_W-1:0] data);
    stack_result_t res;
    int            slot;
    int            s;
    res  = '0;
    slot = NO_ENTRY;
    s    = int'(sel);
    if (s < STACKS) begin
      if (act == spl_pkg::ACT_PUSH) begin
        // The lowest free entry wins.
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (pool_free[i]) slot = i;
        end
        if (slot < DEPTH) begin
          pool_data[slot] = data;
          pool_link[slot] = stack_top[s];
          stack_top[s]    = slot;
          pool_free[slot] = 1'b0;
          pool_used++;
          res.ok = 1'b1;
        end
      end else if (stack_top[s] < DEPTH) begin
        slot            = stack_top[s];
        res.ok          = 1'b1;
        res.data        = pool_data[slot];
        pool_free[slot] = 1'b1;
        stack_top[s]    = pool_link[slot];
        pool_used--;
      end
    end
    return res;
  endfunction

  // Mostly valid stacks, now and then the selector past the last stack.
  function automatic logic [SEL_W-1:0] pick_stack();
    if ($urandom_range(7) == 0) return SEL_W'(BAD_SEL);
    return SEL_W'($urandom_range(STACKS - 1));
  endfunction

  // Send one transaction, with random idle cycles first, and record its expectation.
  task automatic send_op(logic act, logic [SEL_W-1:0] sel, logic signed [DATA_W-1:0] data);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start       = 1'b1;
    action_i    = act;
    stack_sel_i = sel;
    push_data_i = data;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    expected_results.push_back(predict_stack_op(act, sel, data));
  endtask

  // Stop sending and wait until every pending transaction has reported.
  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Pops on empty stacks and both operations on a selector past the last stack.
  task automatic test_empty_and_bad_sel();
    idle_pct = 0;
    for (int s = 0; s < STACKS; s++) send_op(spl_pkg::ACT_POP, SEL_W'(s), $urandom());
    send_op(spl_pkg::ACT_PUSH, SEL_W'(BAD_SEL), $urandom());
    send_op(spl_pkg::ACT_POP, SEL_W'(BAD_SEL), $urandom());
  endtask

  // Extreme data words, LIFO order per stack and a final pop of an emptied stack.
  task automatic test_push_pop_order();
    idle_pct = 0;
    send_op(spl_pkg::ACT_PUSH, SEL_W'(0), 32'sh7fff_ffff);
    send_op(spl_pkg::ACT_PUSH, SEL_W'(1), 32'sh8000_0000);
    send_op(spl_pkg::ACT_PUSH, SEL_W'(2), 32'sh0000_0000);
    send_op(spl_pkg::ACT_PUSH, SEL_W'(0), -32'sd1);
    send_op(spl_pkg::ACT_PUSH, SEL_W'(1), 32'sh5555_5555);
    send_op(spl_pkg::ACT_PUSH, SEL_W'(2), 32'shaaaa_aaaa);
    send_op(spl_pkg::ACT_POP, SEL_W'(0), $urandom());
    send_op(spl_pkg::ACT_POP, SEL_W'(0), $urandom());
    send_op(spl_pkg::ACT_POP, SEL_W'(1), $urandom());
    send_op(spl_pkg::ACT_POP, SEL_W'(2), $urandom());
    send_op(spl_pkg::ACT_POP, SEL_W'(1), $urandom());
    send_op(spl_pkg::ACT_POP, SEL_W'(2), $urandom());
    send_op(spl_pkg::ACT_POP, SEL_W'(0), $urandom());
    wait_drained();
  endtask

  // Random pushes and pops at a given push share and sender idle rate.
  task automatic test_random_mix(int count, int push_pct, int idle);
    idle_pct = idle;
    for (int n = 0; n < count; n++) begin
      send_op(($urandom_range(99) < push_pct) ? spl_pkg::ACT_PUSH : spl_pkg::ACT_POP,
              pick_stack(), $urandom());
    end
    wait_drained();
  endtask

  // Push until the pool is full, then push into the full pool.
  task automatic test_fill_pool(int idle);
    bit paused;
    paused   = 1'b0;
    idle_pct = idle;
    while (pool_used < DEPTH) begin
      send_op(spl_pkg::ACT_PUSH, SEL_W'($urandom_range(STACKS - 1)), $urandom());
      // Let the block run dry once in the middle of the fill.
      if (!paused && pool_used >= DEPTH / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    for (int n = 0; n < 6; n++) send_op(spl_pkg::ACT_PUSH, pick_stack(), $urandom());
    wait_drained();
  endtask

  // Check each result against the oldest pending expectation.
  always @(posedge clk_i) begin
    stack_result_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no transaction pending: done_ok %b pop_data %0d",
                 $time, done_ok_o, pop_data_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (done_ok_o !== want.ok) begin
          $display("%0t: done_ok mismatch: expected %b, actual %b", $time, want.ok, done_ok_o);
          error_count++;
        end
        if (pop_data_o !== want.data) begin
          $display("%0t: pop_data mismatch: expected %0d, actual %0d",
                   $time, want.data, pop_data_o);
          error_count++;
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Reset, then run the tests in turn.
  initial begin
    error_count = 0;
    cycle_count = 0;
    idle_pct    = 0;
    pool_used   = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    action_i    = spl_pkg::ACT_PUSH;
    stack_sel_i = '0;
    push_data_i = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pool_data[i] = '0;
      pool_link[i] = NO_ENTRY;
      pool_free[i] = 1'b1;
    end
    for (int s = 0; s < STACKS; s++) stack_top[s] = NO_ENTRY;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_and_bad_sel();
    test_push_pop_order();
    test_random_mix(60, 55, 0);
    test_random_mix(60, 55, 85);
    test_fill_pool(25);
    test_random_mix(90, 20, 0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/spl_pkg.sv
hw/rtl/spl_ctrl.sv
hw/rtl/spl_dp.sv
hw/rtl/shared_pool_linked_stacks.sv
tb/sv/shared_pool_linked_stacks_tb.sv
